// ===== design/ccse_pkg.sv =====
// Shared types and constants of the ChaCha20 byte stream encryptor.
package ccse_pkg;

   localparam int unsigned WORD_W       = 32;
   localparam int unsigned LANES        = 4;
   localparam int unsigned BLOCK_WORDS  = 16;
   localparam int unsigned BLOCK_BYTES  = 64;
   localparam int unsigned ROUNDS       = 20;
   // two half quarter-round steps per round
   localparam int unsigned ROUND_STEPS  = 2 * ROUNDS;
   localparam int unsigned STEP_W       = $clog2(ROUND_STEPS);
   localparam int unsigned POS_W        = $clog2(BLOCK_BYTES);
   localparam int unsigned CSR_INDEX_W  = 3;
   localparam int unsigned CSR_DATA_W   = 64;

   typedef logic [WORD_W-1:0] word_type;
   typedef logic [7:0][WORD_W-1:0] key_words_type;
   typedef logic [2:0][WORD_W-1:0] nonce_words_type;
   typedef logic [BLOCK_WORDS-1:0][WORD_W-1:0] block_words_type;

   localparam logic [LANES-1:0][WORD_W-1:0] SIGMA = {
      32'h6b206574, 32'h79622d32, 32'h3320646e, 32'h61707865
   };

   // rotation amounts: first half and second half of a quarter round
   localparam logic [4:0] ROT_H0_D = 5'd16;
   localparam logic [4:0] ROT_H0_B = 5'd12;
   localparam logic [4:0] ROT_H1_D = 5'd8;
   localparam logic [4:0] ROT_H1_B = 5'd7;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_KEY_01   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_KEY_23   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_KEY_45   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_KEY_67   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_NONCE_01 = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_NONCE_2  = 3'd5;

   typedef struct packed {
      word_type a;
      word_type b;
      word_type c;
      word_type d;
   } quad_type;

   typedef struct packed {
      logic load;
      logic run;
      logic phase;
   } cell_ctrl_type;

   typedef struct packed {
      logic start;
      logic kill;
   } gen_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } gen_stat_type;

   typedef struct packed {
      logic [7:0] plain_byte;
      logic       end_of_message;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] cipher_byte;
      logic       last_out;
   } rsp_payload_type;

   function automatic word_type rotl(input word_type v, input logic [4:0] n);
      logic [2*WORD_W-1:0] dbl;
      dbl = {v, v} << n;
      return dbl[2*WORD_W-1:WORD_W];
   endfunction

endpackage

// ===== design/ccse_cell.sv =====
// One column cell of the round chain: holds four state words, runs half a quarter round.
module ccse_cell (
   input  logic                    clock,
   input  ccse_pkg::cell_ctrl_type ctrl,
   input  ccse_pkg::quad_type      load_quad,
   input  ccse_pkg::quad_type      route_quad,
   output ccse_pkg::quad_type      state_quad,
   output ccse_pkg::quad_type      step_quad
);

   ccse_pkg::quad_type quad_ff;
   ccse_pkg::quad_type quad_in;
   ccse_pkg::word_type a1;
   ccse_pkg::word_type c1;
   logic [4:0]         rot_d;
   logic [4:0]         rot_b;

   assign rot_d = ctrl.phase ? ccse_pkg::ROT_H1_D : ccse_pkg::ROT_H0_D;
   assign rot_b = ctrl.phase ? ccse_pkg::ROT_H1_B : ccse_pkg::ROT_H0_B;

   // a += b; d ^= a; d <<<= r; c += d; b ^= c; b <<<= r
   always_comb begin
      a1          = quad_ff.a + quad_ff.b;
      step_quad.a = a1;
      step_quad.d = ccse_pkg::rotl(quad_ff.d ^ a1, rot_d);
      c1          = quad_ff.c + step_quad.d;
      step_quad.c = c1;
      step_quad.b = ccse_pkg::rotl(quad_ff.b ^ c1, rot_b);
   end

   always_comb begin
      quad_in = quad_ff;
      if (ctrl.load) begin
         quad_in = load_quad;
      end else if (ctrl.run) begin
         quad_in = route_quad;
      end
   end

   always_ff @(posedge clock) begin
      quad_ff <= quad_in;
   end

   assign state_quad = quad_ff;

endmodule

// ===== design/ccse_block_gen.sv =====
// Keystream block generator: four column cells in a ring plus step sequencer and final add.
module ccse_block_gen (
   input  logic                      clock,
   input  logic                      reset,
   input  ccse_pkg::gen_ctrl_type    ctrl,
   input  ccse_pkg::word_type        start_count,
   input  ccse_pkg::key_words_type   key,
   input  ccse_pkg::nonce_words_type nonce,
   output ccse_pkg::gen_stat_type    stat,
   output ccse_pkg::block_words_type block_words
);

   typedef enum logic [2:0] {
      GEN_IDLE = 3'b001,
      GEN_RUN  = 3'b010,
      GEN_FIN  = 3'b100
   } gen_state_type;

   typedef enum logic [1:0] {
      SHUF_KEEP,
      SHUF_DIAG,
      SHUF_UNDIAG
   } shuffle_type;

   localparam logic [ccse_pkg::STEP_W-1:0] STEP_LAST =
      ccse_pkg::STEP_W'(ccse_pkg::ROUND_STEPS - 1);

   gen_state_type                 state_ff, state_in;
   logic [ccse_pkg::STEP_W-1:0]   step_ff, step_in;
   ccse_pkg::word_type            count_ff, count_in;
   ccse_pkg::cell_ctrl_type       cell_ctrl;
   shuffle_type                   shuffle;
   ccse_pkg::quad_type            load_quad  [ccse_pkg::LANES];
   ccse_pkg::quad_type            route_quad [ccse_pkg::LANES];
   ccse_pkg::quad_type            state_quad [ccse_pkg::LANES];
   ccse_pkg::quad_type            step_quad  [ccse_pkg::LANES];
   ccse_pkg::word_type            load_d     [ccse_pkg::LANES];
   ccse_pkg::word_type            fin_d      [ccse_pkg::LANES];

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      count_in = count_ff;
      if (ctrl.kill) begin
         state_in = GEN_IDLE;
      end else begin
         case (state_ff)
            GEN_IDLE: begin
               if (ctrl.start) begin
                  state_in = GEN_RUN;
                  step_in  = '0;
                  count_in = start_count;
               end
            end
            GEN_RUN: begin
               step_in = step_ff + 1'b1;
               if (step_ff == STEP_LAST) begin
                  state_in = GEN_FIN;
               end
            end
            GEN_FIN: begin
               state_in = GEN_IDLE;
            end
            default: begin
               state_in = GEN_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= GEN_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff <= count_in;
   end

   assign cell_ctrl.load  = (state_ff == GEN_IDLE) && ctrl.start && !ctrl.kill;
   assign cell_ctrl.run   = (state_ff == GEN_RUN) && !ctrl.kill;
   assign cell_ctrl.phase = step_ff[0];

   // Rotate rows between cells after the second half of each round:
   // column rounds hand over into diagonal order, diagonal rounds hand back.
   always_comb begin
      if (!step_ff[0]) begin
         shuffle = SHUF_KEEP;
      end else if (!step_ff[1]) begin
         shuffle = SHUF_DIAG;
      end else begin
         shuffle = SHUF_UNDIAG;
      end
   end

   assign load_d[0] = start_count;
   assign load_d[1] = nonce[0];
   assign load_d[2] = nonce[1];
   assign load_d[3] = nonce[2];
   assign fin_d[0]  = count_ff;
   assign fin_d[1]  = nonce[0];
   assign fin_d[2]  = nonce[1];
   assign fin_d[3]  = nonce[2];

   for (genvar i = 0; i < ccse_pkg::LANES; i++) begin : g_lane
      localparam logic [1:0] LANE = 2'(i);
      localparam logic [1:0] NB1  = LANE + 2'd1;
      localparam logic [1:0] NB2  = LANE + 2'd2;
      localparam logic [1:0] NB3  = LANE + 2'd3;

      assign load_quad[i].a = ccse_pkg::SIGMA[i];
      assign load_quad[i].b = key[i];
      assign load_quad[i].c = key[4 + i];
      assign load_quad[i].d = load_d[i];

      always_comb begin
         route_quad[i].a = step_quad[i].a;
         case (shuffle)
            SHUF_KEEP: begin
               route_quad[i].b = step_quad[LANE].b;
               route_quad[i].c = step_quad[LANE].c;
               route_quad[i].d = step_quad[LANE].d;
            end
            SHUF_DIAG: begin
               route_quad[i].b = step_quad[NB1].b;
               route_quad[i].c = step_quad[NB2].c;
               route_quad[i].d = step_quad[NB3].d;
            end
            SHUF_UNDIAG: begin
               route_quad[i].b = step_quad[NB3].b;
               route_quad[i].c = step_quad[NB2].c;
               route_quad[i].d = step_quad[NB1].d;
            end
            default: begin
               route_quad[i].b = step_quad[LANE].b;
               route_quad[i].c = step_quad[LANE].c;
               route_quad[i].d = step_quad[LANE].d;
            end
         endcase
      end

      ccse_cell u_cell (
         .clock      (clock),
         .ctrl       (cell_ctrl),
         .load_quad  (load_quad[i]),
         .route_quad (route_quad[i]),
         .state_quad (state_quad[i]),
         .step_quad  (step_quad[i])
      );

      // feed-forward add of the input block
      assign block_words[i]      = state_quad[i].a + ccse_pkg::SIGMA[i];
      assign block_words[4 + i]  = state_quad[i].b + key[i];
      assign block_words[8 + i]  = state_quad[i].c + key[4 + i];
      assign block_words[12 + i] = state_quad[i].d + fin_d[i];
   end

   assign stat.busy = (state_ff != GEN_IDLE);
   assign stat.done = (state_ff == GEN_FIN);

endmodule

// ===== design/chacha20_stream_encrypt.sv =====
// Top level of the ChaCha20 (IETF) byte stream encryptor.
//
// Usage: load key and nonce through the csr_ write port (index 0..3 key word
// pairs, 4 nonce words 0/1, 5 nonce word 2) while the block is idle. Each
// req_ transaction carries one message byte and an end-of-message flag; each
// rsp_ transaction returns that byte XORed with the keystream and the flag.
// The block counter starts at 0 for every message and steps every 64 bytes.
// After reset, a register write or a message end the generator restarts
// and builds a block (load, 40 half-round steps of the four-cell round
// ring, feed-forward add); the first byte of a message is taken once that
// block lands, and the result appears in the cycle after the request
// transaction. Throughput: one byte per cycle within a message while the
// current block is present and the output is not stalled; the generator
// starts the next block once the current one lands, so it is ready before
// the 64 bytes of the current block run out.
// Reset clears the registers to zero and the byte position and counter, and
// marks both keystream buffers empty. A stalled result holds in the output
// register and stalls the input; a new byte is still taken in the cycle the
// held result leaves.
module chacha20_stream_encrypt (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  ccse_pkg::req_payload_type            req_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output ccse_pkg::rsp_payload_type            rsp_payload,
   input  logic                                 csr_we,
   input  logic [ccse_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [ccse_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   // configuration registers
   ccse_pkg::key_words_type   key_ff, key_in;
   ccse_pkg::nonce_words_type nonce_ff, nonce_in;
   logic                      cfg_hit;

   // message position and block counter
   logic [ccse_pkg::POS_W-1:0] pos_ff, pos_in;
   ccse_pkg::word_type         count_ff, count_in;

   // current and prefetched keystream blocks
   ccse_pkg::block_words_type cur_buf_ff, cur_buf_in;
   ccse_pkg::block_words_type next_buf_ff, next_buf_in;
   logic                      cur_v_ff, cur_v_in;
   logic                      next_v_ff, next_v_in;
   logic                      gen_next_ff, gen_next_in;

   // generator
   ccse_pkg::gen_ctrl_type    gen_ctrl;
   ccse_pkg::gen_stat_type    gen_stat;
   ccse_pkg::block_words_type gen_words;
   ccse_pkg::word_type        gen_count;
   logic                      gen_to_cur;

   // output register
   logic                      rsp_valid_ff, rsp_valid_in;
   ccse_pkg::rsp_payload_type rsp_payload_ff, rsp_payload_in;

   logic                      accept;
   logic                      last_byte;
   logic                      adv;
   logic                      kill;
   ccse_pkg::word_type        ks_word;
   logic [7:0]                ks_byte;

   // ---------------------------------------------------------------
   // Configuration writes; an index past the list is dropped.
   // ---------------------------------------------------------------
   always_comb begin
      key_in   = key_ff;
      nonce_in = nonce_ff;
      cfg_hit  = 1'b0;
      if (csr_we) begin
         case (csr_index)
            ccse_pkg::REG_KEY_01: begin
               key_in[0] = csr_wdata[31:0];
               key_in[1] = csr_wdata[63:32];
               cfg_hit   = 1'b1;
            end
            ccse_pkg::REG_KEY_23: begin
               key_in[2] = csr_wdata[31:0];
               key_in[3] = csr_wdata[63:32];
               cfg_hit   = 1'b1;
            end
            ccse_pkg::REG_KEY_45: begin
               key_in[4] = csr_wdata[31:0];
               key_in[5] = csr_wdata[63:32];
               cfg_hit   = 1'b1;
            end
            ccse_pkg::REG_KEY_67: begin
               key_in[6] = csr_wdata[31:0];
               key_in[7] = csr_wdata[63:32];
               cfg_hit   = 1'b1;
            end
            ccse_pkg::REG_NONCE_01: begin
               nonce_in[0] = csr_wdata[31:0];
               nonce_in[1] = csr_wdata[63:32];
               cfg_hit     = 1'b1;
            end
            ccse_pkg::REG_NONCE_2: begin
               nonce_in[2] = csr_wdata[31:0];
               cfg_hit     = 1'b1;
            end
            default: begin
               cfg_hit = 1'b0;
            end
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Input handshake: take a byte when the current block is present
   // and the output register is free or leaving this cycle.
   // ---------------------------------------------------------------
   assign req_stall = !cur_v_ff || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign last_byte = req_payload.end_of_message;

   // advance to the next block after the 64th byte of a block
   assign adv  = accept && !last_byte && (&pos_ff);
   // drop every buffered or pending block on a register write or message end
   assign kill = cfg_hit || (accept && last_byte);

   // keystream byte at the current position
   assign ks_word = cur_buf_ff[pos_ff[ccse_pkg::POS_W-1:2]];
   assign ks_byte = 8'(ks_word >> {pos_ff[1:0], 3'b000});

   always_comb begin
      pos_in   = pos_ff;
      count_in = count_ff;
      if (accept) begin
         if (last_byte) begin
            pos_in   = '0;
            count_in = '0;
         end else begin
            pos_in = pos_ff + 1'b1;
            if (adv) begin
               count_in = count_ff + 1'b1;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Block prefetch: generate the current block first, then the next.
   // A generator working on the next block retargets to the current
   // one when the stream advances before it finishes.
   // ---------------------------------------------------------------
   assign gen_ctrl.kill  = kill;
   assign gen_ctrl.start = !gen_stat.busy && !kill && (!cur_v_ff || !next_v_ff);
   assign gen_count      = cur_v_ff ? (count_ff + 1'b1) : count_ff;
   assign gen_to_cur     = !gen_next_ff || adv;

   always_comb begin
      if (gen_ctrl.start) begin
         gen_next_in = cur_v_ff && !adv;
      end else if (adv) begin
         gen_next_in = 1'b0;
      end else begin
         gen_next_in = gen_next_ff;
      end
   end

   always_comb begin
      cur_v_in    = cur_v_ff;
      next_v_in   = next_v_ff;
      cur_buf_in  = cur_buf_ff;
      next_buf_in = next_buf_ff;
      if (kill) begin
         cur_v_in  = 1'b0;
         next_v_in = 1'b0;
      end else begin
         if (adv) begin
            cur_v_in   = next_v_ff;
            next_v_in  = 1'b0;
            cur_buf_in = next_buf_ff;
         end
         if (gen_stat.done) begin
            if (gen_to_cur) begin
               cur_v_in   = 1'b1;
               cur_buf_in = gen_words;
            end else begin
               next_v_in   = 1'b1;
               next_buf_in = gen_words;
            end
         end
      end
   end

   ccse_block_gen u_block_gen (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (gen_ctrl),
      .start_count (gen_count),
      .key         (key_ff),
      .nonce       (nonce_ff),
      .stat        (gen_stat),
      .block_words (gen_words)
   );

   // ---------------------------------------------------------------
   // Output register: load on accept, hold while stalled.
   // ---------------------------------------------------------------
   assign rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);

   always_comb begin
      rsp_payload_in = rsp_payload_ff;
      if (accept) begin
         rsp_payload_in.cipher_byte = req_payload.plain_byte ^ ks_byte;
         rsp_payload_in.last_out    = last_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff       <= '0;
         nonce_ff     <= '0;
         pos_ff       <= '0;
         count_ff     <= '0;
         cur_v_ff     <= 1'b0;
         next_v_ff    <= 1'b0;
         gen_next_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         key_ff       <= key_in;
         nonce_ff     <= nonce_in;
         pos_ff       <= pos_in;
         count_ff     <= count_in;
         cur_v_ff     <= cur_v_in;
         next_v_ff    <= next_v_in;
         gen_next_ff  <= gen_next_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_buf_ff     <= cur_buf_in;
      next_buf_ff    <= next_buf_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   // a prefetched block never exists without the current one
   assert property (@(posedge clock) disable iff (reset) next_v_ff |-> cur_v_ff)
      else $error("next block valid while current block missing");

   // a finished block aimed at the current slot never overwrites a live one
   assert property (@(posedge clock) disable iff (reset)
      (gen_stat.done && !gen_next_ff) |-> !cur_v_ff)
      else $error("generator overwrote a valid current block");

   // while prefetching, the next slot must be empty
   assert property (@(posedge clock) disable iff (reset)
      (gen_stat.busy && gen_next_ff) |-> !next_v_ff)
      else $error("prefetch running with next block already valid");

   // a register write invalidates the keystream
   assert property (@(posedge clock) disable iff (reset)
      cfg_hit |=> (!cur_v_ff && !next_v_ff))
      else $error("keystream survived a register write");

   // message end returns position and counter to zero
   assert property (@(posedge clock) disable iff (reset)
      (accept && last_byte) |=> (pos_ff == '0 && count_ff == '0 && !cur_v_ff))
      else $error("stream state not cleared at message end");

endmodule
